@@ rtl/core/tqrs_pkg.sv @@
// shared constants and types of the two-queue run scheduler
`default_nettype none
package tqrs_pkg;
  localparam int QUEUE_DEPTH = 32;
  localparam int PID_BITS    = 16;

  localparam int FIELD_W = 16;
  localparam int STORE_W = (PID_BITS < FIELD_W) ? PID_BITS : FIELD_W;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = IDX_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST        = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL        = OCC_W'(QUEUE_DEPTH);
  localparam logic [FIELD_W-1:0] TIMESLICE_RST = 16'd100;

  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // decision taken for one request from the ring pointers
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    status_t           status;
    logic              to_next;
    logic              swapped;
  } dec_t;
endpackage
`default_nettype wire

@@ rtl/core/tqrs_if.sv @@
// request and result channel interfaces
`default_nettype none
interface tqrs_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] process_id;
  logic [15:0] cpu_time_used;

  modport source (output valid, operation, process_id, cpu_time_used, input ready);
  modport sink   (input valid, operation, process_id, cpu_time_used, output ready);
endinterface

interface tqrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dispatched_pid;
  logic [1:0]  status;
  logic        went_to_next;
  logic        queues_swapped;

  modport source (output valid, dispatched_pid, status, went_to_next, queues_swapped,
                  input ready);
  modport sink   (input valid, dispatched_pid, status, went_to_next, queues_swapped,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/tqrs_pid_ram.sv @@
// pid memory holding both rings, one write and one registered read port
`default_nettype none
module tqrs_pid_ram
  import tqrs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [STORE_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [STORE_W-1:0] rd_data
);
  logic [STORE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tqrs_queue_ctrl.sv @@
// ring pointers, occupancy, queue roles and timeslice register
`default_nettype none
module tqrs_queue_ctrl
  import tqrs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  input  wire logic               take,
  input  wire logic               op,
  input  wire logic [FIELD_W-1:0] used,
  output dec_t                    dec
);
  logic [FIELD_W-1:0] timeslice_r;
  logic               cur_r, cur_nxt;
  logic [IDX_W-1:0]   head0_r, head1_r, tail0_r, tail1_r;
  logic [IDX_W-1:0]   head0_nxt, head1_nxt, tail0_nxt, tail1_nxt;
  logic [OCC_W-1:0]   occ0_r, occ1_r, occ0_nxt, occ1_nxt;

  logic             enq_ring, deq_ring, swap, full, empty;
  logic [OCC_W-1:0] occ_cur, occ_enq, occ_deq;
  logic [IDX_W-1:0] tail_sel, head_sel;
  logic             do_enq, do_deq;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p);
    return (p == IDX_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    enq_ring = cur_r ^ (used >= timeslice_r);
    occ_cur  = cur_r ? occ1_r : occ0_r;
    swap     = (occ_cur == '0);
    deq_ring = swap ? ~cur_r : cur_r;
    occ_enq  = enq_ring ? occ1_r : occ0_r;
    occ_deq  = deq_ring ? occ1_r : occ0_r;
    full     = (occ_enq == OCC_FULL);
    empty    = (occ_deq == '0);
    tail_sel = enq_ring ? tail1_r : tail0_r;
    head_sel = deq_ring ? head1_r : head0_r;

    dec = '0;
    if (op == OP_ENQUEUE) begin
      dec.wr_en   = !full;
      dec.addr    = {enq_ring, tail_sel};
      dec.status  = full ? ST_FULL : ST_ENQUEUED;
      dec.to_next = (enq_ring != cur_r);
    end else begin
      dec.rd_en   = !empty;
      dec.addr    = {deq_ring, head_sel};
      dec.status  = empty ? ST_EMPTY : ST_DISPATCHED;
      dec.swapped = swap;
    end

    do_enq    = take && dec.wr_en;
    do_deq    = take && dec.rd_en;
    cur_nxt   = (take && op == OP_DISPATCH && swap) ? ~cur_r : cur_r;
    head0_nxt = head0_r;
    head1_nxt = head1_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    occ0_nxt  = occ0_r;
    occ1_nxt  = occ1_r;
    if (do_enq) begin
      if (enq_ring) begin
        tail1_nxt = adv(tail1_r);
        occ1_nxt  = occ1_r + 1'b1;
      end else begin
        tail0_nxt = adv(tail0_r);
        occ0_nxt  = occ0_r + 1'b1;
      end
    end
    if (do_deq) begin
      if (deq_ring) begin
        head1_nxt = adv(head1_r);
        occ1_nxt  = occ1_r - 1'b1;
      end else begin
        head0_nxt = adv(head0_r);
        occ0_nxt  = occ0_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeslice_r <= TIMESLICE_RST;
      cur_r       <= 1'b0;
      head0_r     <= '0;
      head1_r     <= '0;
      tail0_r     <= '0;
      tail1_r     <= '0;
      occ0_r      <= '0;
      occ1_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeslice_r <= cfg_wr_data;
      end
      cur_r   <= cur_nxt;
      head0_r <= head0_nxt;
      head1_r <= head1_nxt;
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
      occ0_r  <= occ0_nxt;
      occ1_r  <= occ1_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/two_queue_run_scheduler_top.sv @@
// two-queue run scheduler: request sequencing, pid memory and result register
// the result register loads in the work state once it is free; the pid memory read is registered
// a new request is accepted only in the idle state, not while the last one is in the work state
// a waiting result does not block the next request; a second result waits in the work state
// reset: both rings empty, ring 0 current, timeslice 100; the pid memory is not cleared
`default_nettype none
module two_queue_run_scheduler_top
  import tqrs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  tqrs_in_if.sink                 in_chan,
  tqrs_out_if.source              out_chan
);
  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t             state_r;
  dec_t               dec, dec_r;
  logic               take, load;
  logic [STORE_W-1:0] rd_data;
  logic               out_valid_r;
  logic [15:0]        out_pid_r;
  status_t            out_status_r;
  logic               out_next_r, out_swap_r;

  assign in_chan.ready = (state_r == S_IDLE);
  assign take          = in_chan.valid && in_chan.ready;
  assign load          = (state_r == S_WORK) && (!out_valid_r || out_chan.ready);

  tqrs_queue_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .op          (in_chan.operation),
    .used        (in_chan.cpu_time_used),
    .dec         (dec)
  );

  tqrs_pid_ram u_ram (
    .clk     (clk),
    .wr_en   (take && dec.wr_en),
    .wr_addr (dec.addr),
    .wr_data (STORE_W'(in_chan.process_id)),
    .rd_en   (take && dec.rd_en),
    .rd_addr (dec.addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (take) begin
            state_r <= S_WORK;
          end
        end
        S_WORK: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_r <= dec;
    end
    if (load) begin
      // read data is held by the memory until the next read request
      out_pid_r    <= (dec_r.status == ST_DISPATCHED) ? 16'(rd_data) : '0;
      out_status_r <= dec_r.status;
      out_next_r   <= dec_r.to_next;
      out_swap_r   <= dec_r.swapped;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.dispatched_pid = out_pid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.went_to_next   = out_next_r;
  assign out_chan.queues_swapped = out_swap_r;
endmodule
`default_nettype wire
